/* rtl/core/sccb_pkg.sv */
`timescale 1ns / 1ps

package sccb_pkg;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W  = 4;
    localparam int BIT_CNT_W = 4;
    localparam int SLOT_CNT_W = 2;

    // command codes
    localparam logic [OP_W-1:0] OP_SLOT  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WR_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_ADDR = 2'd1;

    localparam logic [BYTE_W-1:0] WR_ADDR_RST = 8'h42;
    localparam logic [BYTE_W-1:0] RD_ADDR_RST = 8'h43;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ADDRW    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_REG      = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DATA     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_MID = 4'd4;
    localparam logic [PHASE_W-1:0] PH_START_B  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ADDRR    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RECV     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STOP_END = 4'd8;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // line level bits: {scl, drive, sda}
    localparam logic [2:0] LV_IDLE  = 3'b100;
    localparam logic [2:0] LV_START = 3'b110;
    localparam logic [2:0] LV_LOW   = 3'b000;
    localparam logic [2:0] LV_DRV   = 3'b010;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] sub_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              sda_in;
    } t_cmd;

    typedef struct packed {
        logic              scl_level;
        logic              sda_drive;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_value;
    } t_res;

endpackage

/* rtl/core/sccb_ifs.sv */
`timescale 1ns / 1ps

interface sccb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [sccb_pkg::OP_W-1:0]     op;
    logic [sccb_pkg::BYTE_W-1:0]   sub_addr;
    logic [sccb_pkg::BYTE_W-1:0]   wr_data;
    logic                          sda_in;

    modport source (output valid, op, sub_addr, wr_data, sda_in, input ready);
    modport sink   (input valid, op, sub_addr, wr_data, sda_in, output ready);
endinterface

interface sccb_res_if;
    logic                          valid;
    logic                          ready;
    logic                          scl_level;
    logic                          sda_drive;
    logic                          sda_level;
    logic                          busy_res;
    logic                          done_res;
    logic [sccb_pkg::BYTE_W-1:0]   read_value;

    modport source (output valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                    read_value, input ready);
    modport sink   (input valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                    read_value, output ready);
endinterface

interface sccb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sccb_pkg::CFG_IDX_W-1:0]   index;
    logic [sccb_pkg::BYTE_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/sccb_slot_engine.sv */
`timescale 1ns / 1ps

module sccb_slot_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  sccb_pkg::t_cmd              i_cmd,
    input  logic [sccb_pkg::BYTE_W-1:0] i_wr_addr,
    input  logic [sccb_pkg::BYTE_W-1:0] i_rd_addr,
    output sccb_pkg::t_res              o_res
);

    logic [sccb_pkg::PHASE_W-1:0]    r_phase, n_phase;
    logic [sccb_pkg::BIT_CNT_W-1:0]  r_bit, n_bit;
    logic [sccb_pkg::SLOT_CNT_W-1:0] r_slot, n_slot;
    logic [sccb_pkg::BYTE_W-1:0]     r_shift, n_shift;
    logic                            r_is_read, n_is_read;
    logic [sccb_pkg::BYTE_W-1:0]     r_saved_reg, n_saved_reg;
    logic [sccb_pkg::BYTE_W-1:0]     r_saved_data, n_saved_data;
    logic [sccb_pkg::BYTE_W-1:0]     r_read_byte, n_read_byte;
    logic [2:0]                      r_lv, n_lv;

    logic sent;
    logic stopped;
    logic done;

    always_comb begin
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_slot       = r_slot;
        n_shift      = r_shift;
        n_is_read    = r_is_read;
        n_saved_reg  = r_saved_reg;
        n_saved_data = r_saved_data;
        n_read_byte  = r_read_byte;
        n_lv         = r_lv;
        sent         = 1'b0;
        stopped      = 1'b0;
        done         = 1'b0;

        // shared byte transmitter: eight data bits, then an acknowledge SCL pulse with SDA released
        if (r_bit < sccb_pkg::BITS_PER_BYTE) begin
            if (r_slot == 2'd0) begin
                n_lv   = {1'b0, 1'b1, r_shift[7]};
            end else begin
                n_lv   = {1'b1, 1'b1, r_shift[7]};
                n_shift = {r_shift[6:0], 1'b0};
                n_bit  = r_bit + 4'd1;
            end
        end else begin
            n_lv = (r_slot == 2'd0) ? sccb_pkg::LV_LOW : sccb_pkg::LV_IDLE;
            sent = (r_slot != 2'd0);
        end
        n_slot = (r_slot == 2'd0) ? 2'd1 : 2'd0;

        unique case (r_phase) inside
            sccb_pkg::PH_ADDRW: begin
                if (sent) begin
                    n_phase = sccb_pkg::PH_REG;
                    n_shift = r_saved_reg;
                    n_bit   = '0;
                    n_slot  = '0;
                end
            end
            sccb_pkg::PH_REG: begin
                if (sent) begin
                    n_slot = '0;
                    if (r_is_read) begin
                        n_phase = sccb_pkg::PH_STOP_MID;
                    end else begin
                        n_phase = sccb_pkg::PH_DATA;
                        n_shift = r_saved_data;
                        n_bit   = '0;
                    end
                end
            end
            sccb_pkg::PH_DATA: begin
                if (sent) begin
                    n_phase = sccb_pkg::PH_STOP_END;
                    n_slot  = '0;
                end
            end
            sccb_pkg::PH_ADDRR: begin
                if (sent) begin
                    n_phase = sccb_pkg::PH_RECV;
                    n_shift = '0;
                    n_bit   = '0;
                    n_slot  = '0;
                end
            end
            sccb_pkg::PH_STOP_MID, sccb_pkg::PH_STOP_END: begin
                // stop: SCL low/SDA low, SCL high/SDA low, SCL high/SDA released
                n_bit   = r_bit;
                n_shift = r_shift;
                if (r_slot == 2'd0) begin
                    n_lv   = sccb_pkg::LV_DRV;
                    n_slot = 2'd1;
                end else if (r_slot == 2'd1) begin
                    n_lv   = sccb_pkg::LV_START;
                    n_slot = 2'd2;
                end else begin
                    n_lv    = sccb_pkg::LV_IDLE;
                    n_slot  = 2'd0;
                    stopped = 1'b1;
                end
                if (stopped) begin
                    if (r_phase == sccb_pkg::PH_STOP_MID) begin
                        n_phase = sccb_pkg::PH_START_B;
                    end else begin
                        if (r_is_read) begin
                            n_read_byte = r_shift;
                        end
                        done    = 1'b1;
                        n_phase = sccb_pkg::PH_IDLE;
                        n_bit   = '0;
                    end
                end
            end
            sccb_pkg::PH_START_B: begin
                n_lv    = sccb_pkg::LV_START;
                n_phase = sccb_pkg::PH_ADDRR;
                n_shift = i_rd_addr;
                n_bit   = '0;
                n_slot  = '0;
            end
            sccb_pkg::PH_RECV: begin
                // sample SDA while SCL is high
                n_bit   = r_bit;
                n_shift = r_shift;
                if (r_slot == 2'd0) begin
                    n_lv   = sccb_pkg::LV_LOW;
                    n_slot = 2'd1;
                end else begin
                    n_lv    = sccb_pkg::LV_IDLE;
                    n_shift = {r_shift[6:0], i_cmd.sda_in};
                    n_bit   = r_bit + 4'd1;
                    n_slot  = 2'd0;
                    if (n_bit >= sccb_pkg::BITS_PER_BYTE) begin
                        n_phase = sccb_pkg::PH_STOP_END;
                    end
                end
            end
            default: begin
                n_phase = sccb_pkg::PH_IDLE;
                if (i_cmd.op == sccb_pkg::OP_WRITE || i_cmd.op == sccb_pkg::OP_READ) begin
                    n_saved_reg  = i_cmd.sub_addr;
                    n_saved_data = i_cmd.wr_data;
                    n_is_read    = (i_cmd.op == sccb_pkg::OP_READ);
                    n_lv         = sccb_pkg::LV_START;
                    n_phase      = sccb_pkg::PH_ADDRW;
                    n_shift      = i_wr_addr;
                    n_bit        = '0;
                    n_slot       = '0;
                end else begin
                    n_lv    = sccb_pkg::LV_IDLE;
                    n_shift = r_shift;
                    n_slot  = '0;
                    n_bit   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sccb_pkg::PH_IDLE;
            r_bit        <= '0;
            r_slot       <= '0;
            r_shift      <= '0;
            r_is_read    <= 1'b0;
            r_saved_reg  <= '0;
            r_saved_data <= '0;
            r_read_byte  <= '0;
            r_lv         <= sccb_pkg::LV_IDLE;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_bit        <= n_bit;
            r_slot       <= n_slot;
            r_shift      <= n_shift;
            r_is_read    <= n_is_read;
            r_saved_reg  <= n_saved_reg;
            r_saved_data <= n_saved_data;
            r_read_byte  <= n_read_byte;
            r_lv         <= n_lv;
        end
    end

    assign o_res.scl_level  = n_lv[2];
    assign o_res.sda_drive  = n_lv[1];
    assign o_res.sda_level  = n_lv[1] & n_lv[0];
    assign o_res.busy_res   = (n_phase != sccb_pkg::PH_IDLE);
    assign o_res.done_res   = done;
    assign o_res.read_value = n_read_byte;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> !o_res.busy_res)
        else $error("transaction finished but sequencer still busy");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= sccb_pkg::BITS_PER_BYTE)
        else $error("bit counter ran past one byte");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sccb_pkg::PH_IDLE)
        |-> (r_lv == sccb_pkg::LV_IDLE || r_lv == sccb_pkg::LV_START))
        else $error("lines not idle or start while sequencer idle");

    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == sccb_pkg::PH_IDLE && i_cmd.op == sccb_pkg::OP_WRITE)
        |=> (r_phase == sccb_pkg::PH_ADDRW && r_lv == sccb_pkg::LV_START))
        else $error("write request did not open a transaction");

endmodule

/* rtl/core/sccb_bitbang_master_top.sv */
`timescale 1ns / 1ps

// Channel   | Dir | Handshake     | Payload
// ----------+-----+---------------+-----------------------------------------------
// i_cmd     | in  | valid/ready   | op, sub_addr, wr_data, sda_in (one bus slot)
// o_res     | out | valid/ready   | scl_level, sda_drive, sda_level, busy_res,
//           |     |               | done_res, read_value
// i_cfg     | in  | valid/ready   | index (0 write address, 1 read address), data
//
// Every request is one timing slot and yields exactly one result, passing through the
// input register, then the result register. One request per cycle is sustained while
// o_res is not stalled; the slot sequencer advances once per request and never holds requests back.
// Reset (i_rst_n low at a clock edge) empties both registers, puts the bus idle
// (SCL high, SDA released) and restores the addresses 0x42 and 0x43.
// A stall on o_res holds the result register and the input register; i_cmd.ready
// drops only while both are full and the result is not taken.
// Configuration writes are always taken.

module sccb_bitbang_master_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sccb_cmd_if.sink   i_cmd,
    sccb_res_if.source o_res,
    sccb_cfg_if.sink   i_cfg
);

    // input register
    logic           r_in_valid;
    sccb_pkg::t_cmd r_in;

    // result register
    logic           r_out_valid;
    sccb_pkg::t_res r_out;

    // device addresses
    logic [sccb_pkg::BYTE_W-1:0] r_wr_addr;
    logic [sccb_pkg::BYTE_W-1:0] r_rd_addr;

    sccb_pkg::t_res res;
    logic           advance;

    // move the held request through the sequencer when the result slot frees up
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in.op       <= i_cmd.op;
            r_in.sub_addr <= i_cmd.sub_addr;
            r_in.wr_data  <= i_cmd.wr_data;
            r_in.sda_in   <= i_cmd.sda_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_addr <= sccb_pkg::WR_ADDR_RST;
            r_rd_addr <= sccb_pkg::RD_ADDR_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sccb_pkg::CFG_WR_ADDR: r_wr_addr <= i_cfg.data;
                sccb_pkg::CFG_RD_ADDR: r_rd_addr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    sccb_slot_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_cmd     (r_in),
        .i_wr_addr (r_wr_addr),
        .i_rd_addr (r_rd_addr),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.scl_level  = r_out.scl_level;
    assign o_res.sda_drive  = r_out.sda_drive;
    assign o_res.sda_level  = r_out.sda_level;
    assign o_res.busy_res   = r_out.busy_res;
    assign o_res.done_res   = r_out.done_res;
    assign o_res.read_value = r_out.read_value;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !advance)
        else $error("result register overwritten while stalled");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res.ready) |-> !i_cmd.ready)
        else $error("request taken with both registers full");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed slot produced no result");

endmodule
